// ----- rtl/core/wmmf_pkg.sv -----
// shared types and constants for the window mean/min/max filter
`default_nettype none
package wmmf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_MAX_RADIUS = 3;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned RADIUS_W   = 2;
  localparam int unsigned SIZE_W     = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_RADIUS = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN   = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_DILATE = 2'd2,
    MODE_PASS   = 2'd3
  } filter_mode_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } pixel_op_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WIN  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } filt_state_e;

endpackage
`default_nettype wire

// ----- rtl/core/wmmf_ram.sv -----
// generic single-port-write, registered-read ram
`default_nettype none
module wmmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/window_mean_min_max_filter_core.sv -----
// Square-window mean / erosion / dilation filter over a raster pixel stream.
// Pixels enter in raster order and are kept in one line ram of
// MAX_WIDTH*(2*MAX_RADIUS+1) entries; result k leaves after pixel k+r*W+r is in,
// and drain ticks release the rest of the frame. Each item is handled alone:
// while an item with a result is in work the input is stalled. The window
// is read one entry a cycle through the single ram read port (r counts as 0
// in mode 3) in ST_WIN, then ST_FIN takes the last read, and in mean mode the
// one-bit-a-cycle divider runs in ST_DIV before ST_OUT. A held output stalls
// the next result until it is taken. Mode 3 passes the centre pixel through.
// A configuration write restarts the frame; no clearing pass is needed.
`default_nettype none
module window_mean_min_max_filter_core #(
  parameter int unsigned MAX_WIDTH  = wmmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = wmmf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = wmmf_pkg::DEF_MAX_RADIUS,
  parameter int unsigned PIXEL_BITS = wmmf_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wmmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wmmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            op_i,
  input  wire logic [PIXEL_BITS-1:0]           pixel_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [PIXEL_BITS-1:0]           filtered_value_o,
  output logic                                 end_of_frame_o
);
  import wmmf_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WUW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HUW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RDW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned DW    = RDW + 1;
  localparam int unsigned PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned NWIN  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned CNTW  = $clog2(NWIN + 1);
  localparam int unsigned SUMW  = PIXEL_BITS + CNTW;
  localparam int unsigned DCW   = $clog2(SUMW + 1);
  localparam int unsigned SXW   = WUW + 2;
  localparam int unsigned SYW   = HUW + 2;

  // configuration
  logic [MODE_W-1:0]   mode_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [SIZE_W-1:0]   width_q, height_q;
  logic                cfg_fire, restart;

  logic [31:0]    wtmp, htmp, rtmp;
  logic [WUW-1:0] w_used;
  logic [HUW-1:0] h_used;
  logic [RDW-1:0] r_used, r_eff;

  always_comb begin
    wtmp = 32'(width_q);
    htmp = 32'(height_q);
    rtmp = 32'(radius_q);
    if (wtmp == 32'd0) wtmp = 32'd1;
    else if (wtmp > MAX_WIDTH) wtmp = MAX_WIDTH;
    if (htmp == 32'd0) htmp = 32'd1;
    else if (htmp > MAX_HEIGHT) htmp = MAX_HEIGHT;
    if (rtmp > MAX_RADIUS) rtmp = MAX_RADIUS;
  end
  assign w_used = wtmp[WUW-1:0];
  assign h_used = htmp[HUW-1:0];
  assign r_used = rtmp[RDW-1:0];
  assign r_eff  = (mode_q == MODE_PASS) ? '0 : r_used;

  filt_state_e state_q, state_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MEAN;
      radius_q <= RADIUS_W'(2);
      width_q  <= SIZE_W'(1024);
      height_q <= SIZE_W'(1024);
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position state
  logic [WUW-1:0] in_col_q, out_col_q;
  logic [HUW-1:0] in_row_q, out_row_q;
  logic [AW-1:0]  in_addr_q, out_addr_q;
  logic [PW-1:0]  in_pix_q;
  logic           in_done_q;

  logic in_fire, take_pixel, do_emit, in_last, out_last, out_load;
  logic [PW-1:0] lat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign take_pixel = in_fire & ~in_done_q & (op_i == OP_PIXEL);
  assign lat        = PW'(r_used) * PW'(w_used) + PW'(r_used);
  assign do_emit    = in_fire & (in_done_q | (take_pixel & (in_pix_q >= lat)));
  assign in_last    = (in_row_q == h_used - 1'b1) && (in_col_q == w_used - 1'b1);
  assign out_last   = (out_row_q == h_used - 1'b1) && (out_col_q == w_used - 1'b1);
  assign restart    = cfg_fire | (out_load & out_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_addr_q  <= '0;
      in_pix_q   <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_addr_q <= '0;
    end else if (restart) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_addr_q  <= '0;
      in_pix_q   <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_addr_q <= '0;
    end else begin
      if (take_pixel) begin
        in_pix_q  <= in_pix_q + 1'b1;
        in_addr_q <= (in_addr_q == AW'(DEPTH - 1)) ? '0 : in_addr_q + 1'b1;
        if (in_last) begin
          in_done_q <= 1'b1;
        end else if (in_col_q == w_used - 1'b1) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (out_load) begin
        out_addr_q <= (out_addr_q == AW'(DEPTH - 1)) ? '0 : out_addr_q + 1'b1;
        if (out_col_q == w_used - 1'b1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // window walk
  logic signed [DW-1:0] dx_q, dy_q, r_neg, r_pos;
  logic [AW-1:0]        ra_q, ra_init, ra_next, rd_addr;
  logic [AW:0]          rw, ra_tmp, rn_tmp;
  logic signed [AW+1:0] ad_tmp;
  logic signed [SXW-1:0] sx;
  logic signed [SYW-1:0] sy;
  logic                 in_image, rd_en, rd_pend_q, win_end;
  logic [PIXEL_BITS-1:0] rdata;

  assign r_pos = $signed({1'b0, r_eff});
  assign r_neg = -r_pos;
  assign rw    = (AW + 1)'(r_eff) * (AW + 1)'(w_used);

  always_comb begin
    if ({1'b0, out_addr_q} >= rw) ra_tmp = {1'b0, out_addr_q} - rw;
    else ra_tmp = {1'b0, out_addr_q} + (AW + 1)'(DEPTH) - rw;
    ra_init = ra_tmp[AW-1:0];
    rn_tmp  = {1'b0, ra_q} + (AW + 1)'(w_used);
    if (rn_tmp >= (AW + 1)'(DEPTH)) rn_tmp = rn_tmp - (AW + 1)'(DEPTH);
    ra_next = rn_tmp[AW-1:0];
    ad_tmp  = $signed({2'b00, ra_q}) + (AW + 2)'(dx_q);
    if (ad_tmp < 0) ad_tmp = ad_tmp + (AW + 2)'(DEPTH);
    else if (ad_tmp >= $signed((AW + 2)'(DEPTH))) ad_tmp = ad_tmp - (AW + 2)'(DEPTH);
    rd_addr = ad_tmp[AW-1:0];
    sx = $signed({2'b00, out_col_q}) + SXW'(dx_q);
    sy = $signed({2'b00, out_row_q}) + SYW'(dy_q);
  end

  assign in_image = (sx >= 0) && (sx < $signed({2'b00, w_used}))
                 && (sy >= 0) && (sy < $signed({2'b00, h_used}));
  assign rd_en    = (state_q == ST_WIN) && in_image;
  assign win_end  = (dx_q == r_pos) && (dy_q == r_pos);

  wmmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (take_pixel),
    .waddr_i (in_addr_q),
    .wdata_i (pixel_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // accumulators and serial divider
  logic [SUMW-1:0]       sum_q, num_q, num_init;
  logic [CNTW-1:0]       cnt_q, rem_q;
  logic [CNTW:0]         rem_sh;
  logic [PIXEL_BITS-1:0] mn_q, mx_q;
  logic [DCW-1:0]        div_cnt_q;
  logic                  out_valid_q, out_eof_q;
  logic [PIXEL_BITS-1:0] out_val_q, result;

  // the last window read is still returning while the sum is taken
  assign num_init = sum_q + SUMW'(cnt_q >> 1) + (rd_pend_q ? SUMW'(rdata) : '0);
  assign rem_sh   = {rem_q, num_q[SUMW-1]};
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (mode_q)
      MODE_MEAN:  result = num_q[PIXEL_BITS-1:0];
      MODE_ERODE: result = mn_q;
      default:    result = mx_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (do_emit && !cfg_fire) state_d = ST_WIN;
      ST_WIN:  if (win_end) state_d = ST_FIN;
      ST_FIN:  state_d = (mode_q == MODE_MEAN) ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_cnt_q == DCW'(SUMW - 1)) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      dx_q      <= r_neg;
      dy_q      <= r_neg;
      ra_q      <= ra_init;
      sum_q     <= '0;
      cnt_q     <= '0;
      mn_q      <= '1;
      mx_q      <= '0;
      div_cnt_q <= '0;
    end else begin
      if (state_q == ST_WIN) begin
        if (dx_q == r_pos) begin
          dx_q <= r_neg;
          dy_q <= dy_q + 1'b1;
          ra_q <= ra_next;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
        if (in_image) cnt_q <= cnt_q + 1'b1;
        else mn_q <= '0;
      end
      if (rd_pend_q) begin
        sum_q <= sum_q + SUMW'(rdata);
        if (rdata < mn_q && (state_q != ST_WIN || in_image)) mn_q <= rdata;
        if (rdata > mx_q) mx_q <= rdata;
      end
      if (state_q == ST_FIN) begin
        num_q <= num_init;
        rem_q <= '0;
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
        if (rem_sh >= {1'b0, cnt_q}) begin
          rem_q <= CNTW'(rem_sh - {1'b0, cnt_q});
          num_q <= {num_q[SUMW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[CNTW-1:0];
          num_q <= {num_q[SUMW-2:0], 1'b0};
        end
      end
    end
    if (out_load) begin
      out_val_q <= result;
      out_eof_q <= out_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign end_of_frame_o   = out_eof_q;

`ifndef SYNTHESIS
  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_WIN || state_q == ST_FIN))
    else $error("ram read returned outside the window walk");
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> (state_q == ST_DIV || state_q == ST_OUT))
    else $error("divider left to an unexpected state");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_pixel |-> state_q == ST_IDLE)
    else $error("line ram written while a window is in progress");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (cnt_q != '0 && cnt_q <= CNTW'(NWIN)))
    else $error("window count out of range in mean divide");
`endif
endmodule
`default_nettype wire

// ----- sim/window_mean_min_max_filter_core_test.sv -----
// self-checking testbench for the window mean/min/max filter core
`timescale 1ns / 1ps
`default_nettype none
module window_mean_min_max_filter_core_test;
  import wmmf_pkg::*;

  localparam int unsigned PB = DEF_PIXEL_BITS;
  localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH * (2 * DEF_MAX_RADIUS + 1);
  localparam logic [PB-1:0] FULL_SCALE = '1;

  typedef struct packed {
    logic [PB-1:0] value;
    logic          eof;
  } filt_result_t;

  typedef struct {
    pixel_op_e     op;
    logic [PB-1:0] pix;
    logic          known;
    filt_result_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [PB-1:0] pixel_value;
  logic out_valid;
  logic out_stall;
  logic [PB-1:0] filtered_value;
  logic end_of_frame;

  window_mean_min_max_filter_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .pixel_value_i   (pixel_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .filtered_value_o(filtered_value),
    .end_of_frame_o  (end_of_frame)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [PB-1:0] win_store [STORE_DEPTH];
  logic [1:0]  p_mode;
  logic [1:0]  p_radius;
  logic [10:0] p_width;
  logic [10:0] p_height;
  int unsigned in_col, in_row, out_col, out_row;
  bit          frame_in_done;

  filt_result_t expected_q[$];
  int unsigned  n_errors;
  int unsigned  n_results;
  int unsigned  n_items;
  int unsigned  n_frames;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           hold_recv;

  function automatic int unsigned eff_width();
    if (p_width == 0) return 1;
    if (p_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return p_width;
  endfunction

  function automatic int unsigned eff_height();
    if (p_height == 0) return 1;
    if (p_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
    return p_height;
  endfunction

  function automatic void restart_counters();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic filt_result_t next_filtered(int unsigned w, int unsigned h,
                                                 int unsigned r);
    filt_result_t res;
    int sy, sx;
    int unsigned sum, cnt;
    logic [PB-1:0] mn, mx, v;
    sum = 0;
    cnt = 0;
    mn = FULL_SCALE;
    mx = '0;
    if (r == 0 || p_mode == MODE_PASS) begin
      res.value = win_store[(out_row * w + out_col) % STORE_DEPTH];
    end else begin
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
        for (int dx = -int'(r); dx <= int'(r); dx++) begin
          sy = int'(out_row) + dy;
          sx = int'(out_col) + dx;
          if (sy < 0 || sy >= int'(h) || sx < 0 || sx >= int'(w)) begin
            mn = '0;
          end else begin
            v = win_store[(sy * w + sx) % STORE_DEPTH];
            sum += v;
            cnt++;
            if (v < mn) mn = v;
            if (v > mx) mx = v;
          end
        end
      end
      case (p_mode)
        MODE_MEAN:  res.value = PB'((sum + cnt / 2) / cnt);
        MODE_ERODE: res.value = mn;
        default:    res.value = mx;
      endcase
    end
    res.eof = (out_row == h - 1) && (out_col == w - 1);
    if (res.eof) begin
      restart_counters();
      n_frames++;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  // returns 1 when the item produces a result
  function automatic bit filter_step(pixel_op_e o, logic [PB-1:0] pix,
                                     output filt_result_t res);
    int unsigned w, h, r, p;
    w = eff_width();
    h = eff_height();
    r = p_radius;
    res = '0;
    if (frame_in_done || o == OP_DRAIN) begin
      if (!frame_in_done) return 1'b0;
      res = next_filtered(w, h, r);
      return 1'b1;
    end
    p = in_row * w + in_col;
    win_store[p % STORE_DEPTH] = pix;
    if (in_row == h - 1 && in_col == w - 1) begin
      frame_in_done = 1'b1;
    end else if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (p >= r * w + r) begin
      res = next_filtered(w, h, r);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   p_mode   = data[1:0];
      REG_RADIUS: p_radius = data[1:0];
      REG_WIDTH:  p_width  = data[10:0];
      default:    p_height = data[10:0];
    endcase
    restart_counters();
  endtask

  // wait for all results, then let the block finish any item that gives none
  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic setup(int unsigned mode, int unsigned rad, int unsigned w,
                       int unsigned h);
    wait_idle();
    write_reg(REG_MODE, mode);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one transfer on the input channel; predicts when accepted
  task automatic send_item(pixel_op_e o, logic [PB-1:0] pix, bit known,
                           filt_result_t known_res);
    filt_result_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    pixel_value <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (filter_step(o, pix, res)) begin
      if (known && res != known_res) begin
        n_errors++;
        $display("%0t table row: expected %h/%0b, predictor %h/%0b", $time,
                 known_res.value, known_res.eof, res.value, res.eof);
      end
      expected_q.push_back(res);
    end
  endtask

  task automatic end_send();
    in_valid <= 1'b0;
  endtask

  task automatic drain_frame();
    while (frame_in_done) send_item(OP_DRAIN, PB'($urandom), 1'b0, '0);
    end_send();
  endtask

  // a frame with random content, mostly well-formed
  task automatic random_frame(int unsigned w, int unsigned h);
    int unsigned kind;
    logic [PB-1:0] pix;
    for (int unsigned i = 0; i < w * h; i++) begin
      kind = $urandom_range(15);
      case (kind)
        0: pix = '0;
        1: pix = FULL_SCALE;
        2: pix = PB'($urandom_range(255));
        default: pix = PB'($urandom);
      endcase
      if ($urandom_range(40) == 0) send_item(OP_DRAIN, pix, 1'b0, '0);
      send_item(OP_PIXEL, pix, 1'b0, '0);
    end
    // extra pixels past the frame act as drain ticks
    if ($urandom_range(3) == 0) send_item(OP_PIXEL, PB'($urandom), 1'b0, '0);
    drain_frame();
  endtask

  // output side: stall and check
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          n_errors++;
          $display("%0t unexpected result: actual %h/%0b", $time, filtered_value,
                   end_of_frame);
        end else begin
          filt_result_t exp_res;
          exp_res = expected_q.pop_front();
          if (filtered_value !== exp_res.value) begin
            n_errors++;
            $display("%0t filtered_value: expected %h actual %h", $time,
                     exp_res.value, filtered_value);
          end
          if (end_of_frame !== exp_res.eof) begin
            n_errors++;
            $display("%0t end_of_frame: expected %0b actual %0b", $time,
                     exp_res.eof, end_of_frame);
          end
        end
      end
      out_stall <= hold_recv || (recv_idle_pct != 0 &&
                                 $urandom_range(99) < recv_idle_pct);
    end
  end

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(pixel_op_e o, logic [PB-1:0] pix, bit known,
                                    logic [PB-1:0] v, logic eof);
    stim_row_t rw;
    rw.op = o;
    rw.pix = pix;
    rw.known = known;
    rw.res.value = v;
    rw.res.eof = eof;
    return rw;
  endfunction

  task automatic run_rows();
    foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].pix,
                                    dir_rows[i].known, dir_rows[i].res);
    end_send();
    dir_rows.delete();
  endtask

  initial begin
    int unsigned w, h;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = 1'b0;
    pixel_value = '0;
    out_stall = 1'b0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_errors = 0;
    n_results = 0;
    n_items = 0;
    n_frames = 0;
    p_mode = MODE_MEAN;
    p_radius = 2;
    p_width = 1024;
    p_height = 1024;
    restart_counters();
    foreach (win_store[i]) win_store[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass-through 1x1 frames, early drain, extremes
    write_reg(REG_RADIUS, 0);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    dir_rows.push_back(row(OP_PIXEL, FULL_SCALE, 1, FULL_SCALE, 1));
    dir_rows.push_back(row(OP_PIXEL, '0, 1, '0, 1));
    dir_rows.push_back(row(OP_PIXEL, 16'h5555, 1, 16'h5555, 1));
    dir_rows.push_back(row(OP_PIXEL, 16'haaaa, 1, 16'haaaa, 1));
    run_rows();
    // width and height 0 act as 1; a drain before the frame is in does nothing
    setup(MODE_ERODE, 3, 0, 0);
    dir_rows.push_back(row(OP_DRAIN, 16'h1234, 0, '0, 0));
    dir_rows.push_back(row(OP_PIXEL, FULL_SCALE, 0, '0, 0));
    dir_rows.push_back(row(OP_DRAIN, '0, 1, '0, 1));
    run_rows();
    // erosion on a window reaching outside gives zero; here dilation gives the max
    setup(MODE_DILATE, 1, 2, 2);
    dir_rows.push_back(row(OP_PIXEL, 16'h0001, 0, '0, 0));
    dir_rows.push_back(row(OP_PIXEL, FULL_SCALE, 0, '0, 0));
    dir_rows.push_back(row(OP_DRAIN, '0, 0, '0, 0));
    dir_rows.push_back(row(OP_PIXEL, 16'h0002, 1, FULL_SCALE, 0));
    dir_rows.push_back(row(OP_PIXEL, 16'h0003, 1, FULL_SCALE, 0));
    dir_rows.push_back(row(OP_PIXEL, 16'h7777, 1, FULL_SCALE, 0));
    dir_rows.push_back(row(OP_DRAIN, '0, 1, FULL_SCALE, 0));
    dir_rows.push_back(row(OP_DRAIN, '0, 1, FULL_SCALE, 1));
    run_rows();
    // mean of full scale stays full scale; mode 3 passes the centre
    setup(MODE_MEAN, 3, 3, 2);
    for (int i = 0; i < 6; i++) dir_rows.push_back(row(OP_PIXEL, FULL_SCALE, 0, '0, 0));
    run_rows();
    drain_frame();
    setup(MODE_PASS, 2, 3, 3);
    random_frame(3, 3);
    // a width above the maximum saturates to it, one wide frame
    setup(MODE_DILATE, 0, 2047, 1);
    random_frame(1024, 1);

    // random phases with three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 21 : 0;
      for (int f = 0; f < 10; f++) begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 6);
        if (f == 0) w = $urandom_range(1, 3) == 1 ? 1 : 12;
        setup($urandom_range(3), $urandom_range(3), w, h);
        if (phase == 2 && f == 3) begin
          // long receiver hold while the sender keeps offering
          fork
            begin
              hold_recv = 1'b1;
              repeat (400) @(posedge clk);
              hold_recv = 1'b0;
            end
          join_none
        end
        random_frame(w, h);
        if (f == 6) wait_idle();
      end
    end

    wait_idle();
    $display("items sent %0d, results checked %0d, frames %0d, all modes and radii",
             n_items, n_results, n_frames);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("window_mean_min_max_filter_core: match");
    end else begin
      $display("window_mean_min_max_filter_core: mismatch");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("window_mean_min_max_filter_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
